@@ design/assert_macros.svh @@
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
// Property checked on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`endif

@@ design/tfn_pkg.sv @@
// Package: shared types and constants for the triangle face normal pipeline.
package tfn_pkg;
    localparam int CoordW = 24;
    localparam int NormW = 16;
    localparam int MagW = 49;
    localparam int ShW = 31;
    localparam int SumW = 64;
    localparam int RootW = 32;
    localparam int QW = 17;
    localparam int SqrtSteps = 32;
    localparam int DivSteps = 17;
    // front end, sum, root cells, quotient cells, output register
    localparam int DEF_STAGES = 3 + 1 + SqrtSteps + DivSteps + 1;

    // Payload carried from cell to cell.
    typedef struct packed {
        logic [ShW-1:0]    mag_x;
        logic [ShW-1:0]    mag_y;
        logic [ShW-1:0]    mag_z;
        logic [2:0]        neg;
        logic              degen;
        logic [SumW-1:0]   rem;
        logic [RootW-1:0]  root;
        logic [QW+RootW:0] dr_x;
        logic [QW+RootW:0] dr_y;
        logic [QW+RootW:0] dr_z;
        logic [QW-1:0]     q_x;
        logic [QW-1:0]     q_y;
        logic [QW-1:0]     q_z;
    } cell_t;
endpackage

@@ design/tfn_sqrt_cell.sv @@
// Cell: one restoring square root step, one result bit per cell.
module tfn_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic           aclk,
    input  logic           en,
    input  tfn_pkg::cell_t d,
    output tfn_pkg::cell_t q_reg
);
    localparam int Sh = 2 * (tfn_pkg::SqrtSteps - 1 - STEP);
    logic [tfn_pkg::SumW+1:0] trial;
    logic [tfn_pkg::SumW+1:0] rem_top;
    tfn_pkg::cell_t q_next;

    // Compare the remainder window against 4*root+1.
    always_comb begin
        q_next = d;
        rem_top = {2'b00, d.rem} >> Sh;
        trial = {d.root, 2'b01};
        if (rem_top >= trial) begin
            q_next.rem = d.rem - tfn_pkg::SumW'(trial << Sh);
            q_next.root = {d.root[tfn_pkg::RootW-2:0], 1'b1};
        end else begin
            q_next.root = {d.root[tfn_pkg::RootW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end
endmodule

@@ design/tfn_div_cell.sv @@
// Cell: one restoring division step for all three components.
module tfn_div_cell (
    input  logic           aclk,
    input  logic           en,
    input  tfn_pkg::cell_t d,
    output tfn_pkg::cell_t q_reg
);
    localparam int DW = tfn_pkg::QW + tfn_pkg::RootW + 1;
    tfn_pkg::cell_t q_next;
    logic [DW-1:0] dv;

    function automatic logic [DW:0] step(input logic [DW-1:0] rem,
                                         input logic [DW-1:0] div);
        logic [DW-1:0] sh;
        begin
            sh = {rem[DW-2:0], 1'b0};
            if (sh >= div) step = {sh - div, 1'b1};
            else step = {sh, 1'b0};
        end
    endfunction

    // Shift-subtract on each component; divisor is root with dividend scaled.
    always_comb begin
        logic [DW:0] rx, ry, rz;
        q_next = d;
        dv = DW'(d.root) << tfn_pkg::QW;
        rx = step(d.dr_x, dv);
        ry = step(d.dr_y, dv);
        rz = step(d.dr_z, dv);
        q_next.dr_x = rx[DW:1];
        q_next.dr_y = ry[DW:1];
        q_next.dr_z = rz[DW:1];
        q_next.q_x = {d.q_x[tfn_pkg::QW-2:0], rx[0]};
        q_next.q_y = {d.q_y[tfn_pkg::QW-2:0], ry[0]};
        q_next.q_z = {d.q_z[tfn_pkg::QW-2:0], rz[0]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end
endmodule

@@ design/tfn_front.sv @@
// Front end: edges, cross product, magnitudes and normalizing shift.
module tfn_front (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [tfn_pkg::CoordW-1:0] ax, ay, az, bx, by_coord, bz, cx, cy, cz,
    output tfn_pkg::cell_t                   q_reg
);
    localparam int EW = tfn_pkg::CoordW + 1;
    localparam int NW = tfn_pkg::MagW + 1;
    logic signed [EW-1:0] e0x, e0y, e0z, e1x, e1y, e1z;
    logic signed [2*EW-1:0] p_reg [6];
    logic signed [2*EW-1:0] p_next [6];
    logic signed [NW-1:0] n [3];
    logic [tfn_pkg::MagW-1:0] mag_reg [3];
    logic [tfn_pkg::MagW-1:0] mag_next [3];
    logic [2:0] neg_reg, neg_next;
    logic [tfn_pkg::MagW-1:0] m;
    logic [5:0] lz;
    logic [5:0] msb;
    tfn_pkg::cell_t q_next;

    // Stage 1: edge differences and six products.
    always_comb begin
        e0x = EW'(bx) - EW'(ax);
        e0y = EW'(by_coord) - EW'(ay);
        e0z = EW'(bz) - EW'(az);
        e1x = EW'(cx) - EW'(ax);
        e1y = EW'(cy) - EW'(ay);
        e1z = EW'(cz) - EW'(az);
        p_next[0] = e0y * e1z;
        p_next[1] = e0z * e1y;
        p_next[2] = e0z * e1x;
        p_next[3] = e0x * e1z;
        p_next[4] = e0x * e1y;
        p_next[5] = e0y * e1x;
    end

    // Stage 2: cross components as sign and magnitude.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n[i] = NW'(p_reg[2*i]) - NW'(p_reg[2*i+1]);
            neg_next[i] = n[i][NW-1];
            mag_next[i] = n[i][NW-1] ? tfn_pkg::MagW'(-n[i])
                                     : tfn_pkg::MagW'(n[i]);
        end
    end

    // Stage 3: align the largest magnitude to bit 30.
    always_comb begin
        m = mag_reg[0] | mag_reg[1] | mag_reg[2];
        msb = '0;
        for (int b = 0; b < tfn_pkg::MagW; b++) begin
            if (m[b]) msb = 6'(b);
        end
        lz = '0;
        q_next = '0;
        q_next.neg = neg_reg;
        q_next.degen = (m == '0);
        if (msb >= 6'd30) begin
            lz = msb - 6'd30;
            q_next.mag_x = tfn_pkg::ShW'(mag_reg[0] >> lz);
            q_next.mag_y = tfn_pkg::ShW'(mag_reg[1] >> lz);
            q_next.mag_z = tfn_pkg::ShW'(mag_reg[2] >> lz);
        end else begin
            lz = 6'd30 - msb;
            q_next.mag_x = tfn_pkg::ShW'(mag_reg[0] << lz);
            q_next.mag_y = tfn_pkg::ShW'(mag_reg[1] << lz);
            q_next.mag_z = tfn_pkg::ShW'(mag_reg[2] << lz);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
            mag_reg <= mag_next;
            neg_reg <= neg_next;
            q_reg <= q_next;
        end
    end
endmodule

@@ design/triangle_face_normal.sv @@
// Top level: streaming triangle face normal pipeline.
// Accepts one triangle per clock and delivers one unit normal per clock at full
// throughput. The chain is three front-end stages (edges/products, cross and
// magnitude, alignment), one squaring and sum stage, one cell per root bit of
// the square root and one cell per quotient bit of the division chain, then the
// output register. The whole chain advances together and stalls only when
// m_tready holds off a waiting result.
`include "assert_macros.svh"
module triangle_face_normal (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz: 24 bits each from bit 0 up
    input  logic [215:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // x, y, z normal components (16 bits each), degenerate flag, 7 zero bits
    output logic [55:0]  m_tdata
);
    localparam int CW = tfn_pkg::CoordW;
    localparam int SW = tfn_pkg::SqrtSteps;
    localparam int DWs = tfn_pkg::DivSteps;
    localparam int FrontLat = 3;
    localparam int VLen = FrontLat + 1 + SW + DWs;

    logic en;
    logic [VLen-1:0] vld_reg;
    logic out_vld_reg;
    logic [55:0] out_reg, out_next;
    logic [2*tfn_pkg::ShW-1:0] pw_x, pw_y, pw_z;
    tfn_pkg::cell_t front_q, sum_reg, sum_next;
    tfn_pkg::cell_t div_load;
    tfn_pkg::cell_t sq [SW+1];
    tfn_pkg::cell_t dq [DWs+1];

    // Pipeline advances when the output slot is free or being taken.
    assign en = !out_vld_reg || m_tready;
    assign s_tready = en && aresetn;
    assign m_tvalid = out_vld_reg;
    assign m_tdata = out_reg;

    tfn_front u_front (
        .aclk(aclk), .en(en),
        .ax(s_tdata[0*CW +: CW]), .ay(s_tdata[1*CW +: CW]), .az(s_tdata[2*CW +: CW]),
        .bx(s_tdata[3*CW +: CW]), .by_coord(s_tdata[4*CW +: CW]),
        .bz(s_tdata[5*CW +: CW]), .cx(s_tdata[6*CW +: CW]),
        .cy(s_tdata[7*CW +: CW]), .cz(s_tdata[8*CW +: CW]),
        .q_reg(front_q)
    );

    // Sum of squared aligned magnitudes.
    always_comb begin
        pw_x = front_q.mag_x * front_q.mag_x;
        pw_y = front_q.mag_y * front_q.mag_y;
        pw_z = front_q.mag_z * front_q.mag_z;
        sum_next = front_q;
        sum_next.rem = tfn_pkg::SumW'(pw_x) + tfn_pkg::SumW'(pw_y)
                     + tfn_pkg::SumW'(pw_z);
        sum_next.root = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) sum_reg <= sum_next;
    end

    assign sq[0] = sum_reg;
    for (genvar i = 0; i < SW; i++) begin : g_sqrt
        tfn_sqrt_cell #(.STEP(i)) u_cell (.aclk(aclk), .en(en), .d(sq[i]), .q_reg(sq[i+1]));
    end

    // Load dividends a*32768 + r/2 into the divide chain.
    always_comb begin
        div_load = sq[SW];
        div_load.dr_x = (($bits(div_load.dr_x))'(sq[SW].mag_x) << 15)
                      + ($bits(div_load.dr_x))'(sq[SW].root >> 1);
        div_load.dr_y = (($bits(div_load.dr_y))'(sq[SW].mag_y) << 15)
                      + ($bits(div_load.dr_y))'(sq[SW].root >> 1);
        div_load.dr_z = (($bits(div_load.dr_z))'(sq[SW].mag_z) << 15)
                      + ($bits(div_load.dr_z))'(sq[SW].root >> 1);
        div_load.q_x = '0;
        div_load.q_y = '0;
        div_load.q_z = '0;
    end

    assign dq[0] = div_load;
    for (genvar i = 0; i < DWs; i++) begin : g_div
        tfn_div_cell u_cell (.aclk(aclk), .en(en), .d(dq[i]), .q_reg(dq[i+1]));
    end

    function automatic logic [15:0] fin(input logic [tfn_pkg::QW-1:0] q, input logic ng);
        logic [15:0] s;
        begin
            s = (q > 17'd32767) ? 16'd32767 : q[15:0];
            fin = ng ? 16'(-s) : s;
        end
    endfunction

    // Saturate, apply sign, pack; a degenerate triangle gives zero components.
    always_comb begin
        tfn_pkg::cell_t f;
        f = dq[DWs];
        out_next = '0;
        if (!f.degen) begin
            out_next[15:0]  = fin(f.q_x, f.neg[0]);
            out_next[31:16] = fin(f.q_y, f.neg[1]);
            out_next[47:32] = fin(f.q_z, f.neg[2]);
        end
        out_next[48] = f.degen;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= {vld_reg[VLen-2:0], s_tvalid};
            out_vld_reg <= vld_reg[VLen-1];
        end
        if (en) out_reg <= out_next;
    end

    `ASSERT_IMPL(a_hold, aclk, aresetn, m_tvalid && !m_tready, ##1 m_tvalid)
    `ASSERT_IMPL(a_degen_zero, aclk, aresetn, m_tvalid && m_tdata[48], m_tdata[47:0] == 48'd0)
    `ASSERT_ALWAYS(a_sat, aclk, aresetn, !m_tvalid || (m_tdata[15:0] != 16'h8000))
endmodule

@@ test/testbench.sv @@
// Testbench for the triangle face normal pipeline: directed and random triangles.
module testbench;
    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        degen;
    } normal_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [215:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;

    logic [215:0] tri_queue[$];
    normal_t      normal_queue[$];
    int           errors = 0;
    bit           stim_done = 1'b0;
    bit           in_xfer = 1'b0;
    int           hold_cycles = 0;

    triangle_face_normal uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 aclk = ~aclk;

    // integer square root, floor
    function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // unit normal of one triangle in Q1.15
    function automatic normal_t face_normal(input logic [215:0] d);
        longint      v[9];
        longint      n[3];
        logic [63:0] mag[3];
        bit          neg[3];
        logic [63:0] m, s, r, q;
        logic [15:0] o[3];
        normal_t     res;
        for (int i = 0; i < 9; i++) v[i] = longint'($signed(d[24*i +: 24]));
        n[0] = (v[4]-v[1])*(v[8]-v[2]) - (v[5]-v[2])*(v[7]-v[1]);
        n[1] = (v[5]-v[2])*(v[6]-v[0]) - (v[3]-v[0])*(v[8]-v[2]);
        n[2] = (v[3]-v[0])*(v[7]-v[1]) - (v[4]-v[1])*(v[6]-v[0]);
        m = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = n[i] < 0;
            mag[i] = neg[i] ? -n[i] : n[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) return '{16'd0, 16'd0, 16'd0, 1'b1};
        while (m >= (64'd1 << 31)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (m < (64'd1 << 30)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        s = 0;
        for (int i = 0; i < 3; i++) s = s + mag[i] * mag[i];
        r = floor_sqrt(s);
        if (r == 0) r = 1;
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 64'd32768 + (r >> 1)) / r;
            if (q > 32767) q = 32767;
            o[i] = neg[i] ? 16'(-q) : 16'(q);
        end
        res = '{o[0], o[1], o[2], 1'b0};
        return res;
    endfunction

    function automatic logic [23:0] rand_coord(input int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 2000)) - 1000);
            2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            default: return 24'($signed($urandom_range(0, 20)) - 10);
        endcase
    endfunction

    function automatic logic [215:0] pack_tri(input logic [23:0] c[9]);
        logic [215:0] d;
        for (int i = 0; i < 9; i++) d[24*i +: 24] = c[i];
        return d;
    endfunction

    // stimulus: directed cases then random triangles
    initial begin
        logic [23:0] c[9];
        int mode;
        // zero area: all vertices equal
        c = '{default: 24'h0};
        tri_queue.push_back(pack_tri(c));
        // collinear vertices
        c = '{24'd0, 24'd0, 24'd0, 24'd5, 24'd5, 24'd5, 24'd10, 24'd10, 24'd10};
        tri_queue.push_back(pack_tri(c));
        // axis-aligned right triangles: full-scale components, both signs for z
        c = '{24'd0, 24'd0, 24'd0, 24'd256, 24'd0, 24'd0, 24'd0, 24'd256, 24'd0};
        tri_queue.push_back(pack_tri(c));
        c = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd256, 24'd0, 24'd256, 24'd0, 24'd0};
        tri_queue.push_back(pack_tri(c));
        c = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 24'd1};
        tri_queue.push_back(pack_tri(c));
        c = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd1, 24'd1, 24'd0, 24'd0};
        tri_queue.push_back(pack_tri(c));
        // extreme coordinates
        c = '{24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h800000,
              24'h800000, 24'h7FFFFF, 24'h800000};
        tri_queue.push_back(pack_tri(c));
        c = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
              24'h7FFFFF, 24'h800000, 24'h800000};
        tri_queue.push_back(pack_tri(c));
        c = '{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
              24'h800000, 24'h800000, 24'h7FFFFF};
        tri_queue.push_back(pack_tri(c));
        c = '{24'hFFFFFF, 24'h0, 24'h1, 24'h1, 24'hFFFFFF, 24'h0, 24'h0, 24'h1, 24'hFFFFFF};
        tri_queue.push_back(pack_tri(c));
        for (int k = 0; k < 1040; k++) begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++) c[i] = rand_coord(mode);
            // occasional degenerate: C on line AB
            if ($urandom_range(0, 19) == 0)
                for (int i = 0; i < 3; i++) c[6+i] = c[3+i];
            tri_queue.push_back(pack_tri(c));
        end
    end

    // driver: bursts and gaps, changes at falling edge
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_xfer)
                tri_queue.pop_front();
            // an offered item stays on the bus until it transfers
            if (!s_tvalid || in_xfer) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (tri_queue.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= tri_queue[0];
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // receiver stall pattern with one long hold-off
    int rx_count = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            rx_count <= rx_count + 1;
            if (rx_count == 300) hold_cycles <= 200;
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ((rx_count / 16) % 3 != 0) ? ($urandom_range(0, 3) != 0) : 1'b1;
            end
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge aclk) begin
        normal_t got;
        normal_t exp_n;
        in_xfer <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                normal_queue.push_back(face_normal(s_tdata));
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[48]};
                if (normal_queue.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transfer, expected none, actual %h", $time, m_tdata);
                end else begin
                    exp_n = normal_queue.pop_front();
                    if (got.nx !== exp_n.nx) begin
                        errors++;
                        $display("%0t: x component expected %h actual %h", $time,
                                 exp_n.nx, got.nx);
                    end
                    if (got.ny !== exp_n.ny) begin
                        errors++;
                        $display("%0t: y component expected %h actual %h", $time,
                                 exp_n.ny, got.ny);
                    end
                    if (got.nz !== exp_n.nz) begin
                        errors++;
                        $display("%0t: z component expected %h actual %h", $time,
                                 exp_n.nz, got.nz);
                    end
                    if (got.degen !== exp_n.degen) begin
                        errors++;
                        $display("%0t: degenerate expected %b actual %b", $time,
                                 exp_n.degen, got.degen);
                    end
                end
            end
        end
    end

    // reset, then wait for the pipeline to drain
    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait (stim_done);
        wait (normal_queue.size() == 0);
        repeat (tfn_pkg::DEF_STAGES + 20) @(posedge aclk);
        if (errors == 0 && normal_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ triangle_face_normal.f @@
+incdir+design
design/tfn_pkg.sv
design/tfn_sqrt_cell.sv
design/tfn_div_cell.sv
design/tfn_front.sv
design/triangle_face_normal.sv
test/testbench.sv
